/* hdl/pil_pkg.sv */
// Package for the positional insert list: item structs, status codes,
// cell operation codes and controller state encoding. No dependencies.
package pil_pkg;

    localparam int POS_W  = 6;
    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] value_t;

    typedef enum logic [1:0] {
        ST_ELEM    = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_BWD = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] position;
        value_t           value;
    } in_item_t;

    typedef struct packed {
        status_t status;
        logic    direction;
        value_t  element;
        logic    last;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_HOLD      = 2'd0,
        OP_INSERT    = 2'd1,
        OP_ROT_LEFT  = 2'd2,
        OP_ROT_RIGHT = 2'd3
    } cell_op_t;

    // Control broadcast from the controller to every cell of the chain.
    typedef struct packed {
        cell_op_t         op;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] count;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_REJECT = 2'd1,
        S_FWD    = 2'd2,
        S_BWD    = 2'd3
    } state_t;

endpackage

/* hdl/pil_cell.sv */
// One storage cell of the list chain; holds one list entry.
// Depends on pil_pkg for the control struct and value type.
module pil_cell #(
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  pil_pkg::cell_ctrl_t ctrl,
    input  pil_pkg::value_t    new_value,
    input  pil_pkg::value_t    prev_value,
    input  pil_pkg::value_t    next_value,
    input  pil_pkg::value_t    head_value,
    input  pil_pkg::value_t    tail_value,
    output pil_pkg::value_t    value
);

    localparam logic [pil_pkg::POS_W-1:0] IDX = pil_pkg::POS_W'(INDEX);

    pil_pkg::value_t value_reg;
    pil_pkg::value_t value_next;
    logic [pil_pkg::POS_W-1:0] last_idx;

    assign last_idx = ctrl.count - pil_pkg::POS_W'(1);

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            pil_pkg::OP_HOLD:
            begin
                value_next = value_reg;
            end
            pil_pkg::OP_INSERT:
            begin
                // The cell at the insert point loads the new value; cells
                // behind it take their front neighbor's entry.
                if (IDX == ctrl.pos)
                    value_next = new_value;
                else if (IDX > ctrl.pos)
                    value_next = prev_value;
            end
            pil_pkg::OP_ROT_LEFT:
            begin
                if (IDX == last_idx)
                    value_next = head_value;
                else if (IDX < last_idx)
                    value_next = next_value;
            end
            pil_pkg::OP_ROT_RIGHT:
            begin
                if (IDX == '0)
                    value_next = tail_value;
                else if (IDX < ctrl.count)
                    value_next = prev_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* hdl/positional_insert_list.sv */
// Positional insert list: an accepted insert of a list with N entries after the update
// gives 2*N result items, one per cycle when out_ready stays high; a rejected item gives one.
// The next item is accepted only when the controller is back in idle, which it reaches as
// the last result of the previous item enters the output register.
// The rate is set by the rotation of the cell chain, one entry moved out per cycle.
// Reset (rst_n, asynchronous) empties the list and idles the controller; entries are not cleared.
module positional_insert_list #(
    parameter int CAPACITY = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pil_pkg::in_item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pil_pkg::out_item_t   out_item
);

    // The count must hold CAPACITY itself; the tail index only needs CAPACITY-1.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    pil_pkg::state_t state_reg;
    pil_pkg::state_t state_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] remain_reg;
    logic [CW-1:0] remain_next;
    pil_pkg::status_t reject_status_reg;
    pil_pkg::status_t reject_status_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    pil_pkg::out_item_t out_item_reg;
    pil_pkg::out_item_t out_item_next;

    pil_pkg::cell_ctrl_t cell_ctrl;
    pil_pkg::value_t     cell_value [CAPACITY];
    pil_pkg::value_t     head_value;
    pil_pkg::value_t     tail_value;
    logic [IW-1:0]       tail_idx;

    logic slot_free;
    logic accept;
    logic pos_bad;
    logic list_full;
    logic emit;
    logic pass_done;

    // The output register is free when empty or being drained this cycle.
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == pil_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;

    // The position check comes before the full check, as the status codes require.
    assign pos_bad   = in_item.position > pil_pkg::POS_W'(count_reg);
    assign list_full = (count_reg == CAP_COUNT);
    assign pass_done = (remain_reg == CW'(1));

    // The chain of cells holds the list in order, entry 0 at the front.
    // Forward pass: read cell 0, then rotate the live entries left by one.
    // Backward pass: read the tail cell, then rotate right by one.
    // After each full pass of count rotations the list is back in place.
    assign head_value = cell_value[0];
    assign tail_idx   = IW'(count_reg - CW'(1));
    assign tail_value = cell_value[tail_idx];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            pil_cell #(
                .INDEX(gi)
            ) u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl),
                .new_value  (in_item.value),
                .prev_value ((gi == 0) ? tail_value : cell_value[(gi == 0) ? 0 : gi - 1]),
                .next_value ((gi == CAPACITY - 1) ? head_value
                                                  : cell_value[(gi == CAPACITY - 1) ? gi : gi + 1]),
                .head_value (head_value),
                .tail_value (tail_value),
                .value      (cell_value[gi])
            );
        end
    endgenerate

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pil_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (pos_bad || list_full)
                        state_next = pil_pkg::S_REJECT;
                    else
                        state_next = pil_pkg::S_FWD;
                end
            end
            pil_pkg::S_REJECT:
            begin
                if (slot_free)
                    state_next = pil_pkg::S_IDLE;
            end
            pil_pkg::S_FWD:
            begin
                if (slot_free && pass_done)
                    state_next = pil_pkg::S_BWD;
            end
            pil_pkg::S_BWD:
            begin
                if (slot_free && pass_done)
                    state_next = pil_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pil_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the controller: cell operation, result item and counters.
    always_comb
    begin
        cell_ctrl.op       = pil_pkg::OP_HOLD;
        cell_ctrl.pos      = in_item.position;
        cell_ctrl.count    = pil_pkg::POS_W'(count_reg);
        emit               = 1'b0;
        out_item_next      = out_item_reg;
        count_next         = count_reg;
        remain_next        = remain_reg;
        reject_status_next = reject_status_reg;

        unique case (state_reg)
            pil_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (pos_bad)
                        reject_status_next = pil_pkg::ST_INVALID;
                    else
                        reject_status_next = pil_pkg::ST_FULL;
                    if (!pos_bad && !list_full)
                    begin
                        cell_ctrl.op = pil_pkg::OP_INSERT;
                        count_next   = count_reg + CW'(1);
                        remain_next  = count_reg + CW'(1);
                    end
                end
            end
            pil_pkg::S_REJECT:
            begin
                emit                    = slot_free;
                out_item_next.status    = reject_status_reg;
                out_item_next.direction = pil_pkg::DIR_FWD;
                out_item_next.element   = '0;
                out_item_next.last      = 1'b1;
            end
            pil_pkg::S_FWD:
            begin
                if (slot_free)
                begin
                    emit                    = 1'b1;
                    cell_ctrl.op            = pil_pkg::OP_ROT_LEFT;
                    out_item_next.status    = pil_pkg::ST_ELEM;
                    out_item_next.direction = pil_pkg::DIR_FWD;
                    out_item_next.element   = head_value;
                    out_item_next.last      = 1'b0;
                    remain_next = pass_done ? count_reg : remain_reg - CW'(1);
                end
            end
            pil_pkg::S_BWD:
            begin
                if (slot_free)
                begin
                    emit                    = 1'b1;
                    cell_ctrl.op            = pil_pkg::OP_ROT_RIGHT;
                    out_item_next.status    = pil_pkg::ST_ELEM;
                    out_item_next.direction = pil_pkg::DIR_BWD;
                    out_item_next.element   = tail_value;
                    out_item_next.last      = pass_done;
                    remain_next             = remain_reg - CW'(1);
                end
            end
            default:
            begin
                cell_ctrl.op = pil_pkg::OP_HOLD;
            end
        endcase

        if (!emit)
            out_item_next = out_item_reg;
    end

    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pil_pkg::S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        out_item_reg      <= out_item_next;
        reject_status_reg <= reject_status_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* tb/positional_insert_list_tb.sv */
// Self-checking testbench for the positional insert list: directed and random inserts,
// with results compared against a behavioral list kept inside the bench.
// Depends on pil_pkg and positional_insert_list.
module positional_insert_list_tb;

    localparam int LIST_CAP  = 32;
    localparam int MAX_POS   = (1 << pil_pkg::POS_W) - 1;
    localparam int NUM_ITEMS = 170;
    // Longest burst is two passes over a full list; a margin on top covers the drain.
    localparam int DRAIN_CYCLES = 2 * LIST_CAP + 16;

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Block interface. Every input holds a known value from time zero.
    logic               in_valid  = 1'b0;
    logic               in_ready;
    pil_pkg::in_item_t  in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    pil_pkg::out_item_t out_item;

    positional_insert_list #(
        .CAPACITY (LIST_CAP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Behavioral copy of the list. Only entries below list_len are ever read.
    pil_pkg::value_t    list_model [LIST_CAP];
    int                 list_len = 0;
    pil_pkg::out_item_t expected_results [$];

    int err_count     = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sent          = 0;

    // One row of the directed table. When typed is set, the row carries its
    // expected rejection directly instead of going through the list model.
    typedef struct packed {
        logic [pil_pkg::POS_W-1:0] position;
        pil_pkg::value_t           value;
        logic                      typed;
        pil_pkg::status_t          status;
    } directed_row_t;

    directed_row_t directed_rows [$];

    function automatic pil_pkg::out_item_t make_result(pil_pkg::status_t st, logic dir,
                                                       pil_pkg::value_t elem, logic lst);
        pil_pkg::out_item_t r;
        r.status    = st;
        r.direction = dir;
        r.element   = elem;
        r.last      = lst;
        return r;
    endfunction

    // Apply one accepted insert to the list model and queue every result it causes.
    // A position past the end is checked before the full condition, and both
    // rejections leave the list untouched and give a single marked item.
    task automatic predict_insert(input pil_pkg::in_item_t it);
        int total;
        int k;
        if (int'(it.position) > list_len)
        begin
            expected_results.push_back(
                make_result(pil_pkg::ST_INVALID, pil_pkg::DIR_FWD, '0, 1'b1));
        end
        else if (list_len >= LIST_CAP)
        begin
            expected_results.push_back(
                make_result(pil_pkg::ST_FULL, pil_pkg::DIR_FWD, '0, 1'b1));
        end
        else
        begin
            // Later entries move back by one place to open the slot.
            for (int i = list_len; i > int'(it.position); i--)
                list_model[i] = list_model[i-1];
            list_model[it.position] = it.value;
            list_len++;
            total = 2 * list_len;
            k = 0;
            // Front-to-back pass, then back-to-front; only the final item is marked.
            for (int i = 0; i < list_len; i++)
            begin
                expected_results.push_back(make_result(pil_pkg::ST_ELEM, pil_pkg::DIR_FWD,
                                                       list_model[i], k == total - 1));
                k++;
            end
            for (int i = list_len - 1; i >= 0; i--)
            begin
                expected_results.push_back(make_result(pil_pkg::ST_ELEM, pil_pkg::DIR_BWD,
                                                       list_model[i], k == total - 1));
                k++;
            end
        end
    endtask

    // Offer one item, starting at a falling edge. Random idle cycles come first;
    // after acceptance the task returns at the next falling edge, so the caller
    // can drive the following item without dropping valid in between.
    task automatic send_insert(input pil_pkg::in_item_t it, input logic typed,
                               input pil_pkg::status_t st);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (typed)
            expected_results.push_back(make_result(st, pil_pkg::DIR_FWD, '0, 1'b1));
        else
            predict_insert(it);
        sent++;
        @(negedge clk);
    endtask

    // Idle profile by progress: sender light and receiver heavy first, then the
    // other way round, and a final stretch in which neither side idles.
    task automatic pick_idle_phase();
        if (sent < 65)
        begin
            send_idle_pct = 15;
            recv_idle_pct = 65;
        end
        else if (sent < 130)
        begin
            send_idle_pct = 65;
            recv_idle_pct = 15;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // Receiver stalls are drawn fresh at every falling edge.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result checker: every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        pil_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected item: status %0d dir %0b elem %0d last %0b",
                             out_item.status, out_item.direction, out_item.element,
                             out_item.last);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_item.status !== want.status || out_item.direction !== want.direction
                    || out_item.element !== want.element || out_item.last !== want.last)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: want status %0d dir %0b elem %0d last %0b, ",
                                 want.status, want.direction, want.element, want.last,
                                 "got status %0d dir %0b elem %0d last %0b",
                                 out_item.status, out_item.direction, out_item.element,
                                 out_item.last);
                end
            end
        end
    end

    // Stimulus.
    initial
    begin
        pil_pkg::in_item_t it;
        int                pick;
        logic [31:0]       raw;

        // Directed table. Positions are chosen against the list length that the
        // preceding rows build up: empty list first, then the extremes of the value
        // range at the front, appends at the end, middle inserts, and positions
        // just past the end and at the field maximum.
        directed_rows.push_back({6'd1,  32'sd5,        1'b1, pil_pkg::ST_INVALID});
        directed_rows.push_back({6'd63, -32'sd1,       1'b1, pil_pkg::ST_INVALID});
        directed_rows.push_back({6'd0,  32'sh7FFFFFFF, 1'b0, pil_pkg::ST_ELEM});
        directed_rows.push_back({6'd0,  32'sh80000000, 1'b0, pil_pkg::ST_ELEM});
        directed_rows.push_back({6'd2,  32'sd0,        1'b0, pil_pkg::ST_ELEM});
        directed_rows.push_back({6'd1,  -32'sd1,       1'b0, pil_pkg::ST_ELEM});
        directed_rows.push_back({6'd5,  32'sd1,        1'b1, pil_pkg::ST_INVALID});
        directed_rows.push_back({6'd4,  32'sh55555555, 1'b0, pil_pkg::ST_ELEM});
        directed_rows.push_back({6'd0,  32'shAAAAAAAA, 1'b0, pil_pkg::ST_ELEM});
        directed_rows.push_back({6'd3,  32'sd12345,    1'b0, pil_pkg::ST_ELEM});
        directed_rows.push_back({6'd63, 32'sd0,        1'b1, pil_pkg::ST_INVALID});
        directed_rows.push_back({6'd8,  32'sd7,        1'b1, pil_pkg::ST_INVALID});
        directed_rows.push_back({6'd32, 32'sd9,        1'b1, pil_pkg::ST_INVALID});
        directed_rows.push_back({6'd7,  -32'sd100,     1'b0, pil_pkg::ST_ELEM});
        directed_rows.push_back({6'd6,  32'sd1,        1'b0, pil_pkg::ST_ELEM});

        // Reset is held from time zero and released at a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            pick_idle_phase();
            it.position = directed_rows[i].position;
            it.value    = directed_rows[i].value;
            send_insert(it, directed_rows[i].typed, directed_rows[i].status);
        end

        // Random part. Most items are positions past the end, so that accepted
        // inserts, and with them the long result bursts, spread over all idle
        // phases. About one item in four is a valid insert, which fills the list
        // and then meets the full rejection well before the item count runs out.
        while (sent < NUM_ITEMS)
        begin
            pick_idle_phase();
            pick = $urandom_range(0, 9);
            if (pick < 2)
                it.position = pil_pkg::POS_W'($urandom_range(0, list_len));
            else if (pick < 9)
                it.position = pil_pkg::POS_W'($urandom_range(list_len + 1, MAX_POS));
            else
                it.position = pil_pkg::POS_W'($urandom_range(0, MAX_POS));
            raw = $urandom;
            case ($urandom_range(0, 7))
                0:       it.value = 32'sh7FFFFFFF;
                1:       it.value = 32'sh80000000;
                2:       it.value = -32'sd1;
                default: it.value = raw;
            endcase
            send_insert(it, 1'b0, pil_pkg::ST_ELEM);
        end
        in_valid <= 1'b0;

        // Drain everything still expected, then watch a while longer for strays.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && expected_results.size() == 0)
            $display("positional_insert_list_tb: done, clean");
        else
            $display("positional_insert_list_tb: done, errors");
        $finish;
    end

    // Watchdog. The slowest correct run is well under a tenth of this.
    initial
    begin
        #800000;
        $display("positional_insert_list_tb: done, errors");
        $finish;
    end

endmodule
